// ===== rtl/ffbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffbsa_pkg
// Shared constants, node kind codes and the state size lookup of the
// first-fit buffer slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffbsa_pkg;

  // Field widths
  localparam int unsigned POS_W    = 8;
  localparam int unsigned PLAN_W   = 9;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned SLOT_OUT_W = 8;
  localparam int unsigned CNT_OUT_W  = 9;
  localparam int unsigned OFFS_W   = 13;
  localparam int unsigned CURS_W   = 14;
  localparam int unsigned SIZE_W   = 6;

  // Default slot table depth
  localparam int unsigned MAX_SLOTS_DEF = 256;

  // Limits of one plan
  localparam logic [CURS_W-1:0] STATE_LIMIT    = 14'd8192;
  localparam logic [PLAN_W-1:0] POSITION_LIMIT = 9'd256;

  // Node kinds that carry state
  localparam logic [KIND_W-1:0] KIND_CLIP  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CACHE = 4'd6;
  localparam logic [KIND_W-1:0] KIND_FSM   = 4'd8;

  localparam logic [SIZE_W-1:0] BYTES_CLIP  = 6'd8;
  localparam logic [SIZE_W-1:0] BYTES_CACHE = 6'd24;
  localparam logic [SIZE_W-1:0] BYTES_FSM   = 6'd32;

  // State bytes needed by one node kind
  function automatic logic [SIZE_W-1:0] kind_state_bytes(input logic [KIND_W-1:0] kind);
    logic [SIZE_W-1:0] bytes;
    case (kind)
      KIND_CLIP:  bytes = BYTES_CLIP;
      KIND_CACHE: bytes = BYTES_CACHE;
      KIND_FSM:   bytes = BYTES_FSM;
      default:    bytes = '0;
    endcase
    return bytes;
  endfunction

  // Round a byte count up to the next multiple of eight
  function automatic logic [CURS_W-1:0] round_up_eight(input logic [CURS_W-1:0] v);
    logic [CURS_W-1:0] sum;
    sum = v + 14'd7;
    return {sum[CURS_W-1:3], 3'b000};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ffbsa_ram.sv =====
// ----------------------------------------------------------------------------
// ffbsa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffbsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_buffer_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_buffer_slot_allocator_unit
// Assigns each plan instruction a buffer slot by first-fit search over a slot
// table of owner last-use positions, and lays out eight-aligned node state.
// ----------------------------------------------------------------------------
// Flow: an item goes from IDLE to WRITE with reuse off or an empty table, and
//   through SCAN first with reuse on; the scan reads one entry per cycle through
//   the single table read port and stops at the first hit or the table end.
// Throughput: one item at a time; the next item is taken once the result is
//   loaded into the output register.
// Reset: synchronous active-low; clears counters, flag and handshake state,
//   sets reuse_enable to 1. The slot table has no reset and needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_buffer_slot_allocator_unit #(
  parameter int unsigned MAX_SLOTS = ffbsa_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic                               cfg_reuse_enable,
  // Input items
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_start_plan,
  input  wire logic [ffbsa_pkg::POS_W-1:0]        in_last_use_position,
  input  wire logic [ffbsa_pkg::KIND_W-1:0]       in_node_kind,
  // Result items
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ffbsa_pkg::SLOT_OUT_W-1:0]        out_slot_index,
  output logic [ffbsa_pkg::OFFS_W-1:0]            out_state_base,
  output logic [ffbsa_pkg::CNT_OUT_W-1:0]         out_slots_in_use,
  output logic [ffbsa_pkg::CURS_W-1:0]            out_state_total,
  output logic                                    out_overflow
);

  import ffbsa_pkg::*;

  localparam int unsigned SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  // Control and counters
  logic [1:0]        state_r, state_nxt;
  logic              reuse_r, reuse_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PLAN_W-1:0] pos_r, pos_nxt;
  logic [CURS_W-1:0] cursor_r, cursor_nxt;
  logic              ovf_r, ovf_nxt;

  // Scan pipeline
  logic [CNT_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [SLOT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic              found_r, found_nxt;
  logic [SLOT_W-1:0] found_idx_r, found_idx_nxt;

  // Item payload held during the work
  logic [POS_W-1:0]  last_r, last_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [OFFS_W-1:0]     out_offs_r, out_offs_nxt;
  logic [CNT_OUT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [CURS_W-1:0]     out_total_r, out_total_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // Table port
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  logic [POS_W-1:0]  ram_q;

  // Intermediate values
  logic                  in_fire, out_free;
  logic [CNT_W-1:0]      count_eff;
  logic [PLAN_W-1:0]     pos_eff;
  logic                  hit, scan_end;
  logic [SLOT_W-1:0]     slot_sel;
  logic [CNT_W-1:0]      count_new;
  logic [CURS_W-1:0]     offs_al, offs_sum, cursor_new, offs_res;
  logic                  space_ovf, table_full;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
  logic [CNT_W+CNT_OUT_W-1:0]   cnt_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign count_eff = in_start_plan ? '0 : count_r;
  assign pos_eff   = in_start_plan ? '0 : pos_r;

  // Compare the entry read last cycle against the current position
  assign hit      = cmp_valid_r && ({1'b0, ram_q} < pos_r);
  assign scan_end = cmp_valid_r && ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == count_r);

  // Slot choice and state layout for the write step
  assign table_full = (count_r >= MAX_CNT);
  assign slot_sel   = found_r ? found_idx_r : (table_full ? '0 : count_r[SLOT_W-1:0]);
  assign count_new  = (!found_r && !table_full) ? count_r + CNT_W'(1) : count_r;
  assign offs_al    = round_up_eight(cursor_r);
  assign offs_sum   = offs_al + CURS_W'(size_r);
  assign space_ovf  = (offs_sum > STATE_LIMIT);
  assign cursor_new = space_ovf ? cursor_r : offs_sum;
  assign offs_res   = (space_ovf || offs_al >= STATE_LIMIT) ? '0 : offs_al;
  assign slot_ext   = {{SLOT_OUT_W{1'b0}}, slot_sel};
  assign cnt_ext    = {{CNT_OUT_W{1'b0}}, count_new};

  // Table read and write strobes
  assign ram_re    = (state_r == S_SCAN) && (rd_addr_r < count_r);
  assign ram_we    = (state_r == S_WRITE) && out_free && (found_r || !table_full);
  assign ram_waddr = slot_sel;

  ffbsa_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_SLOTS),
    .AW    (SLOT_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (last_r),
    .re    (ram_re),
    .raddr (rd_addr_r[SLOT_W-1:0]),
    .rdata (ram_q)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    reuse_nxt     = reuse_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    cursor_nxt    = cursor_r;
    ovf_nxt       = ovf_r;
    rd_addr_nxt   = rd_addr_r;
    cmp_valid_nxt = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    last_nxt      = last_r;
    size_nxt      = size_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_slot_nxt  = out_slot_r;
    out_offs_nxt  = out_offs_r;
    out_cnt_nxt   = out_cnt_r;
    out_total_nxt = out_total_r;
    out_ovf_nxt   = out_ovf_r;

    // Take a configuration write
    if (cfg_valid && cfg_ready) begin
      reuse_nxt = cfg_reuse_enable;
    end

    case (state_r)
      S_IDLE: begin
        // Accept an item, open a new plan if asked
        if (in_fire) begin
          last_nxt    = in_last_use_position;
          size_nxt    = kind_state_bytes(in_node_kind);
          count_nxt   = count_eff;
          pos_nxt     = pos_eff;
          cursor_nxt  = in_start_plan ? '0 : cursor_r;
          ovf_nxt     = (in_start_plan ? 1'b0 : ovf_r) || (pos_eff >= POSITION_LIMIT);
          found_nxt   = 1'b0;
          rd_addr_nxt = '0;
          if (reuse_r && (count_eff != '0)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_SCAN: begin
        // Issue one table read per cycle, check the previous one
        if (ram_re) begin
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = rd_addr_r[SLOT_W-1:0];
          rd_addr_nxt   = rd_addr_r + CNT_W'(1);
        end
        if (hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_WRITE;
        end else if (scan_end) begin
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_WRITE;
        end
      end
      S_WRITE: begin
        // Commit slot and state layout, load the result
        if (out_free) begin
          count_nxt     = count_new;
          cursor_nxt    = cursor_new;
          ovf_nxt       = ovf_r || space_ovf || (!found_r && table_full);
          pos_nxt       = (pos_r < POSITION_LIMIT) ? pos_r + PLAN_W'(1) : pos_r;
          out_valid_nxt = 1'b1;
          out_slot_nxt  = slot_ext[SLOT_OUT_W-1:0];
          out_offs_nxt  = offs_res[OFFS_W-1:0];
          out_cnt_nxt   = cnt_ext[CNT_OUT_W-1:0];
          out_total_nxt = round_up_eight(cursor_new);
          out_ovf_nxt   = ovf_r || space_ovf || (!found_r && table_full);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reuse_r     <= 1'b1;
      count_r     <= '0;
      pos_r       <= '0;
      cursor_r    <= '0;
      ovf_r       <= 1'b0;
      rd_addr_r   <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reuse_r     <= reuse_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      cursor_r    <= cursor_nxt;
      ovf_r       <= ovf_nxt;
      rd_addr_r   <= rd_addr_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    found_idx_r <= found_idx_nxt;
    last_r      <= last_nxt;
    size_r      <= size_nxt;
    out_slot_r  <= out_slot_nxt;
    out_offs_r  <= out_offs_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_slot_index   = out_slot_r;
  assign out_state_base   = out_offs_r;
  assign out_slots_in_use = out_cnt_r;
  assign out_state_total  = out_total_r;
  assign out_overflow     = out_ovf_r;

endmodule

`default_nettype wire
